>>> hw/rtl/gwns_pkg.sv
`timescale 1ns / 1ps
package gwns_pkg;

  localparam int DEF_MAX_COLUMNS = 32;
  localparam int DEF_MAX_ROWS    = 32;
  localparam int COORD_W         = 6;
  localparam int DIST_W          = 11;
  localparam logic [DIST_W-1:0] DIST_LIMIT = 11'd2047;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNREACH   = 2'd1,
    ST_AT_TARGET = 2'd2,
    ST_NO_TARGET = 2'd3
  } status_t;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [1:0] NB_LEFT  = 2'd0;
  localparam logic [1:0] NB_RIGHT = 2'd1;
  localparam logic [1:0] NB_UP    = 2'd2;
  localparam logic [1:0] NB_DOWN  = 2'd3;

  typedef struct packed {
    logic [4:0]        next_x;
    logic [4:0]        next_y;
    logic [1:0]        step_direction;
    logic [4:0]        target_x;
    logic [4:0]        target_y;
    logic [DIST_W-1:0] path_length;
    status_t           status;
  } result_t;

endpackage

>>> hw/rtl/grid_wavefront_next_step.sv
`timescale 1ns / 1ps
// Next-step planner on a scored grid. Input beats either load one cell score
// (action 0) or ask for the next step from a position (action 1). A load is
// taken when idle and gives no output beat. A query gives one output beat
// with the chosen neighbor, its direction, the target, the path length and a
// status code.
// A query runs on one sequencer that shares a single read port of each grid
// memory. It scans the grid for the target, clears the distance map, then
// runs wavefront sweeps that visit every cell and each neighbor of each
// reached cell, and at last picks the neighbor.
// The input stalls for the whole query. The output register holds the beat
// while the receiver stalls; loads are still taken then, and a finished query
// waits until the output register frees.
// Reset sets both grid size registers to 32 and the kept target to (0,0);
// the score memory holds nothing defined until cells are loaded.
module grid_wavefront_next_step
  import gwns_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [4:0]         cell_x,
  input  logic [4:0]         cell_y,
  input  logic signed [15:0] score,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         next_x,
  output logic [4:0]         next_y,
  output logic [1:0]         step_direction,
  output logic [4:0]         target_x,
  output logic [4:0]         target_y,
  output logic [10:0]        path_length,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [COORD_W-1:0] grid_width, grid_height;
  logic [COORD_W-1:0] w_eff, h_eff;
  logic               eng_ready, res_valid, out_free, accept;
  result_t            res;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {26'd0, grid_height} : {26'd0, grid_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 6'd32;
      grid_height <= 6'd32;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        grid_height <= pwdata[5:0];
      end else begin
        grid_width <= pwdata[5:0];
      end
    end
  end

  always_comb begin
    if (grid_width < 6'd2) begin
      w_eff = 6'd2;
    end else if (9'(grid_width) > 9'(MAX_COLUMNS)) begin
      w_eff = COORD_W'(MAX_COLUMNS);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height < 6'd2) begin
      h_eff = 6'd2;
    end else if (9'(grid_height) > 9'(MAX_ROWS)) begin
      h_eff = COORD_W'(MAX_ROWS);
    end else begin
      h_eff = grid_height;
    end
  end

  assign in_stall = !eng_ready;
  assign accept   = in_valid && eng_ready;
  assign out_free = !out_valid || !out_stall;

  gwns_engine #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (action),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .score    (score),
    .grid_w   (w_eff),
    .grid_h   (h_eff),
    .out_free (out_free),
    .ready    (eng_ready),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      next_x         <= res.next_x;
      next_y         <= res.next_y;
      step_direction <= res.step_direction;
      target_x       <= res.target_x;
      target_y       <= res.target_y;
      path_length    <= res.path_length;
      status         <= res.status;
    end
  end

endmodule

>>> hw/rtl/gwns_engine.sv
`timescale 1ns / 1ps
module gwns_engine
  import gwns_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               action,
  input  logic [4:0]         cell_x,
  input  logic [4:0]         cell_y,
  input  logic signed [15:0] score,
  input  logic [COORD_W-1:0] grid_w,
  input  logic [COORD_W-1:0] grid_h,
  input  logic               out_free,
  output logic               ready,
  output logic               res_valid,
  output result_t            res
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int DW = DIST_W + 1;

  typedef enum logic [16:0] {
    S_IDLE      = 17'b00000000000000001,
    S_SCAN_RD   = 17'b00000000000000010,
    S_SCAN_CHK  = 17'b00000000000000100,
    S_DECIDE    = 17'b00000000000001000,
    S_INIT_RD   = 17'b00000000000010000,
    S_INIT_WR   = 17'b00000000000100000,
    S_SEED_T    = 17'b00000000001000000,
    S_SEED_C    = 17'b00000000010000000,
    S_VIS_RD    = 17'b00000000100000000,
    S_VIS_CHK   = 17'b00000001000000000,
    S_NB_SEL    = 17'b00000010000000000,
    S_NB_CHK    = 17'b00000100000000000,
    S_SWEEP_END = 17'b00001000000000000,
    S_PICK_SEL  = 17'b00010000000000000,
    S_PICK_CHK  = 17'b00100000000000000,
    S_FINISH    = 17'b01000000000000000,
    S_EMIT      = 17'b10000000000000000
  } state_t;

  function automatic logic [AW-1:0] cell_idx(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
    return AW'(x) * AW'(MAX_ROWS) + AW'(y);
  endfunction

  state_t state;

  logic signed [15:0] score_mem [CELL_COUNT];
  logic [DW-1:0]      dist_mem  [CELL_COUNT];
  logic signed [15:0] score_q;
  logic [DW-1:0]      dist_q;

  logic [COORD_W-1:0] sx, sy, tx, ty;
  logic [4:0]         cx, cy;
  logic [1:0]         nb;
  logic [DIST_W-1:0]  nv, dcur, bestd, plen;
  logic               changed, found, picked;
  logic signed [15:0] best_score;
  logic [4:0]         rnx, rny;
  logic [1:0]         rdir;
  status_t            rstatus;

  logic               load_we;
  logic [AW-1:0]      load_wa;
  logic               dist_we;
  logic [AW-1:0]      dist_wa, dist_ra;
  logic [DW-1:0]      dist_wd;

  logic               nb_ok;
  logic [COORD_W-1:0] nbx, nby;
  logic [1:0]         nb_dir;
  logic               last_y, last_x, adv_done;
  logic [COORD_W-1:0] adv_sx, adv_sy;
  logic               relax_hit, is_cur, cell_live;
  logic [COORD_W-1:0] cx_w, cy_w;

  assign cx_w = {1'b0, cx};
  assign cy_w = {1'b0, cy};

  always_comb begin
    nb_ok  = 1'b0;
    nbx    = sx;
    nby    = sy;
    nb_dir = DIR_LEFT;
    case (nb)
      NB_LEFT: begin
        nb_ok  = (sx != '0);
        nbx    = sx - 1'b1;
        nb_dir = DIR_LEFT;
      end
      NB_RIGHT: begin
        nb_ok  = ({1'b0, sx} + 1'b1) < {1'b0, grid_w};
        nbx    = sx + 1'b1;
        nb_dir = DIR_RIGHT;
      end
      NB_UP: begin
        nb_ok  = (sy != '0);
        nby    = sy - 1'b1;
        nb_dir = DIR_UP;
      end
      default: begin
        nb_ok  = ({1'b0, sy} + 1'b1) < {1'b0, grid_h};
        nby    = sy + 1'b1;
        nb_dir = DIR_DOWN;
      end
    endcase
  end

  always_comb begin
    last_y   = ({1'b0, sy} + 1'b1) >= {1'b0, grid_h};
    last_x   = ({1'b0, sx} + 1'b1) >= {1'b0, grid_w};
    adv_sy   = last_y ? '0 : sy + 1'b1;
    adv_sx   = last_y ? sx + 1'b1 : sx;
    adv_done = last_y && last_x;
  end

  assign cell_live = !dist_q[DIST_W] && (dist_q[DIST_W-1:0] != '0);
  assign relax_hit = !dist_q[DIST_W] &&
                     ((dist_q[DIST_W-1:0] == '0) || (dist_q[DIST_W-1:0] > nv));
  assign is_cur    = (nbx == cx_w) && (nby == cy_w);

  assign load_we = accept && !action &&
                   (9'(cell_x) < 9'(MAX_COLUMNS)) && (9'(cell_y) < 9'(MAX_ROWS));
  assign load_wa = cell_idx({1'b0, cell_x}, {1'b0, cell_y});

  always_comb begin
    dist_we = 1'b0;
    dist_wa = cell_idx(sx, sy);
    dist_wd = '0;
    dist_ra = cell_idx(sx, sy);
    unique case (state)
      S_INIT_WR: begin
        dist_we = 1'b1;
        dist_wd = score_q[15] ? {1'b1, {DIST_W{1'b0}}} : '0;
      end
      S_SEED_T: begin
        dist_we = 1'b1;
        dist_wa = cell_idx(tx, ty);
        dist_wd = DW'(1);
      end
      S_SEED_C: begin
        dist_we = 1'b1;
        dist_wa = cell_idx(cx_w, cy_w);
      end
      S_NB_SEL, S_PICK_SEL: begin
        dist_ra = cell_idx(nbx, nby);
      end
      S_NB_CHK: begin
        dist_we = relax_hit;
        dist_wa = cell_idx(nbx, nby);
        dist_wd = {1'b0, nv};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      score_mem[load_wa] <= score;
    end
    score_q <= score_mem[cell_idx(sx, sy)];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tx      <= '0;
      ty      <= '0;
      sx      <= '0;
      sy      <= '0;
      nb      <= '0;
      found   <= 1'b0;
      changed <= 1'b0;
      picked  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && action) begin
            cx    <= cell_x;
            cy    <= cell_y;
            sx    <= '0;
            sy    <= '0;
            found <= 1'b0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (score_q != 16'sd0 && (!found || score_q >= best_score)) begin
            found      <= 1'b1;
            best_score <= score_q;
            tx         <= sx;
            ty         <= sy;
          end
          sx    <= adv_sx;
          sy    <= adv_sy;
          state <= adv_done ? S_DECIDE : S_SCAN_RD;
        end
        S_DECIDE: begin
          rnx  <= cx;
          rny  <= cy;
          rdir <= DIR_UP;
          plen <= '0;
          sx   <= '0;
          sy   <= '0;
          if (!found) begin
            rstatus <= ST_NO_TARGET;
            state   <= S_EMIT;
          end else if (cx_w >= grid_w || cy_w >= grid_h) begin
            rstatus <= ST_UNREACH;
            state   <= S_EMIT;
          end else if (cx_w == tx && cy_w == ty) begin
            rstatus <= ST_AT_TARGET;
            state   <= S_EMIT;
          end else begin
            rstatus <= ST_OK;
            state   <= S_INIT_RD;
          end
        end
        S_INIT_RD: begin
          state <= S_INIT_WR;
        end
        S_INIT_WR: begin
          sx    <= adv_sx;
          sy    <= adv_sy;
          state <= adv_done ? S_SEED_T : S_INIT_RD;
        end
        S_SEED_T: begin
          state <= S_SEED_C;
        end
        S_SEED_C: begin
          sx      <= '0;
          sy      <= '0;
          changed <= 1'b0;
          dcur    <= '0;
          state   <= S_VIS_RD;
        end
        S_VIS_RD: begin
          state <= S_VIS_CHK;
        end
        S_VIS_CHK: begin
          if (cell_live) begin
            nv    <= (dist_q[DIST_W-1:0] >= DIST_LIMIT) ? DIST_LIMIT
                                                        : dist_q[DIST_W-1:0] + 1'b1;
            nb    <= NB_LEFT;
            state <= S_NB_SEL;
          end else begin
            sx    <= adv_sx;
            sy    <= adv_sy;
            state <= adv_done ? S_SWEEP_END : S_VIS_RD;
          end
        end
        S_NB_SEL: begin
          if (nb_ok) begin
            state <= S_NB_CHK;
          end else if (nb == NB_DOWN) begin
            sx    <= adv_sx;
            sy    <= adv_sy;
            state <= adv_done ? S_SWEEP_END : S_VIS_RD;
          end else begin
            nb <= nb + 1'b1;
          end
        end
        S_NB_CHK: begin
          if (relax_hit) begin
            changed <= 1'b1;
            if (is_cur) begin
              dcur <= nv;
            end
          end
          if (nb == NB_DOWN) begin
            sx    <= adv_sx;
            sy    <= adv_sy;
            state <= adv_done ? S_SWEEP_END : S_VIS_RD;
          end else begin
            nb    <= nb + 1'b1;
            state <= S_NB_SEL;
          end
        end
        S_SWEEP_END: begin
          if (dcur != '0) begin
            sx     <= cx_w;
            sy     <= cy_w;
            nb     <= NB_LEFT;
            picked <= 1'b0;
            state  <= S_PICK_SEL;
          end else if (!changed) begin
            rstatus <= ST_UNREACH;
            state   <= S_EMIT;
          end else begin
            sx      <= '0;
            sy      <= '0;
            changed <= 1'b0;
            state   <= S_VIS_RD;
          end
        end
        S_PICK_SEL: begin
          if (nb_ok) begin
            state <= S_PICK_CHK;
          end else if (nb == NB_DOWN) begin
            state <= S_FINISH;
          end else begin
            nb <= nb + 1'b1;
          end
        end
        S_PICK_CHK: begin
          if (cell_live && (!picked || dist_q[DIST_W-1:0] < bestd)) begin
            picked <= 1'b1;
            bestd  <= dist_q[DIST_W-1:0];
            rnx    <= nbx[4:0];
            rny    <= nby[4:0];
            rdir   <= nb_dir;
          end
          if (nb == NB_DOWN) begin
            state <= S_FINISH;
          end else begin
            nb    <= nb + 1'b1;
            state <= S_PICK_SEL;
          end
        end
        S_FINISH: begin
          if (picked) begin
            plen <= dcur - 1'b1;
          end else begin
            rstatus <= ST_UNREACH;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_EMIT) && out_free;

  always_comb begin
    res.next_x         = rnx;
    res.next_y         = rny;
    res.step_direction = rdir;
    res.target_x       = tx[4:0];
    res.target_y       = ty[4:0];
    res.path_length    = plen;
    res.status         = rstatus;
  end

endmodule

>>> tb/sv/grid_wavefront_next_step_test.sv
`timescale 1ns / 1ps
module grid_wavefront_next_step_test;
  import gwns_pkg::*;

  localparam int COLS = 32;
  localparam int ROWS = 32;
  localparam logic [2:0] REG_WIDTH = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd4;
  localparam bit ACT_LOAD = 1'b0;
  localparam bit ACT_QUERY = 1'b1;
  localparam int FILL_ZERO = 0;
  localparam int FILL_SMALL = 1;
  localparam int FILL_ANY = 2;
  localparam int HOLD_CYCLES = 6000;
  localparam longint CYCLE_LIMIT = 64'd2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [4:0] cell_x = '0;
  logic [4:0] cell_y = '0;
  logic signed [15:0] score = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] next_x, next_y, target_x, target_y;
  logic [1:0] step_direction, status;
  logic [10:0] path_length;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grid_wavefront_next_step u_top (.*);

  typedef struct {
    bit          act;
    logic [4:0]  x;
    logic [4:0]  y;
    logic signed [15:0] s;
    bit          fixed;
    result_t     want;
  } stim_row_t;

  logic signed [15:0] cell_score [COLS*ROWS];
  int          wave_dist [COLS*ROWS];
  logic [4:0]  kept_x, kept_y;
  int          width_reg, height_reg;
  result_t     pending_steps [$];
  int          mismatch_count = 0;
  longint      cycle_count = 0;
  int          stall_left = 0;
  bit          quiet_out = 1'b0;
  bit          hold_out = 1'b0;
  bit          hold_req = 1'b0;
  bit          stim_done = 1'b0;
  stim_row_t   directed [$];

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    wait (hold_req);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out = 1'b0;
  end

  function automatic int clamp_dim(int v);
    if (v < 2) return 2;
    if (v > COLS) return COLS;
    return v;
  endfunction

  function automatic bit lower_dist(int i, int nv);
    if (wave_dist[i] == 0 || wave_dist[i] > nv) begin
      wave_dist[i] = nv;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_row(bit act, logic [4:0] x, logic [4:0] y,
                                  logic signed [15:0] s, bit fixed, result_t want);
    stim_row_t row;
    row.act = act;
    row.x = x;
    row.y = y;
    row.s = s;
    row.fixed = fixed;
    row.want = want;
    directed = {directed, row};
  endfunction

  function automatic result_t plan_step(logic [4:0] cx, logic [4:0] cy);
    result_t r;
    int w, h, cur, bestd, best, v, d, nv;
    bit found, changed, picked;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    r.next_x = cx;
    r.next_y = cy;
    r.step_direction = DIR_UP;
    r.path_length = '0;
    r.status = ST_OK;
    found = 0;
    best = 0;
    for (int x = 0; x < w; x++)
      for (int y = 0; y < h; y++) begin
        v = cell_score[x*ROWS+y];
        if (v != 0 && (!found || v >= best)) begin
          found = 1;
          best = v;
          kept_x = 5'(x);
          kept_y = 5'(y);
        end
      end
    if (!found) r.status = ST_NO_TARGET;
    if (r.status == ST_OK && (cx >= w || cy >= h)) r.status = ST_UNREACH;
    if (r.status == ST_OK && cx == kept_x && cy == kept_y) r.status = ST_AT_TARGET;
    if (r.status == ST_OK) begin
      cur = cx * ROWS + cy;
      for (int x = 0; x < w; x++)
        for (int y = 0; y < h; y++)
          wave_dist[x*ROWS+y] = (cell_score[x*ROWS+y] < 0) ? -1 : 0;
      wave_dist[kept_x*ROWS+kept_y] = 1;
      wave_dist[cur] = 0;
      while (wave_dist[cur] == 0) begin
        changed = 0;
        for (int x = 0; x < w; x++)
          for (int y = 0; y < h; y++) begin
            d = wave_dist[x*ROWS+y];
            if (d > 0) begin
              nv = (d >= 2047) ? 2047 : d + 1;
              if (x > 0 && lower_dist((x-1)*ROWS+y, nv)) changed = 1;
              if (x + 1 < w && lower_dist((x+1)*ROWS+y, nv)) changed = 1;
              if (y > 0 && lower_dist(x*ROWS+y-1, nv)) changed = 1;
              if (y + 1 < h && lower_dist(x*ROWS+y+1, nv)) changed = 1;
            end
          end
        if (!changed) break;
      end
      if (wave_dist[cur] <= 0) r.status = ST_UNREACH;
      else begin
        bestd = 100000;
        picked = 0;
        if (cx > 0) begin
          v = wave_dist[(cx-1)*ROWS+cy];
          if (v > 0 && v < bestd) begin
            bestd = v; r.next_x = 5'(cx - 1); r.next_y = cy;
            r.step_direction = DIR_LEFT; picked = 1;
          end
        end
        if (cx + 1 < w) begin
          v = wave_dist[(cx+1)*ROWS+cy];
          if (v > 0 && v < bestd) begin
            bestd = v; r.next_x = 5'(cx + 1); r.next_y = cy;
            r.step_direction = DIR_RIGHT; picked = 1;
          end
        end
        if (cy > 0) begin
          v = wave_dist[cx*ROWS+cy-1];
          if (v > 0 && v < bestd) begin
            bestd = v; r.next_x = cx; r.next_y = 5'(cy - 1);
            r.step_direction = DIR_UP; picked = 1;
          end
        end
        if (cy + 1 < h) begin
          v = wave_dist[cx*ROWS+cy+1];
          if (v > 0 && v < bestd) begin
            bestd = v; r.next_x = cx; r.next_y = 5'(cy + 1);
            r.step_direction = DIR_DOWN; picked = 1;
          end
        end
        if (picked) r.path_length = 11'(wave_dist[cur] - 1);
        else begin
          r.status = ST_UNREACH;
          r.next_x = cx; r.next_y = cy; r.step_direction = DIR_UP;
        end
      end
    end
    r.target_x = kept_x;
    r.target_y = kept_y;
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, int value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_WIDTH) width_reg = value & 6'h3f;
    else height_reg = value & 6'h3f;
  endtask

  task automatic drain_results();
    while (pending_steps.size() != 0) @(posedge clk);
    idle_cycles(20);
  endtask

  task automatic send_beat(bit act, logic [4:0] x, logic [4:0] y, logic signed [15:0] s,
                           bit fixed, result_t want, bit gaps);
    result_t r;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      idle_cycles($urandom_range(1, 5));
    end
    in_valid <= 1'b1;
    action <= act; cell_x <= x; cell_y <= y; score <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_LOAD) cell_score[x*ROWS+y] = s;
    else begin
      r = plan_step(x, y);
      if (fixed && r != want) begin
        $display("%0t predictor disagrees with table: expected %p actual %p", $time, want, r);
        mismatch_count++;
      end
      pending_steps = {pending_steps, r};
    end
  endtask

  task automatic fill_grid(int mode);
    result_t none;
    logic signed [15:0] s;
    none = '0;
    for (int x = 0; x < clamp_dim(width_reg); x++)
      for (int y = 0; y < clamp_dim(height_reg); y++) begin
        case (mode)
          FILL_ZERO: s = 16'sd0;
          FILL_SMALL: begin
            if ($urandom_range(0, 5) == 0) s = -16'sd1 - 16'($urandom_range(0, 32767));
            else if ($urandom_range(0, 3) == 0) s = 16'sd0;
            else s = 16'($urandom_range(1, 20));
          end
          default: s = 16'($urandom);
        endcase
        send_beat(ACT_LOAD, 5'(x), 5'(y), s, 1'b0, none, 1'b0);
      end
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_out) out_stall <= 1'b1;
    else if (quiet_out) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else out_stall <= 1'b0;
    if (!rst && out_valid && !out_stall) begin
      got.next_x = next_x; got.next_y = next_y; got.step_direction = step_direction;
      got.target_x = target_x; got.target_y = target_y;
      got.path_length = path_length; got.status = status_t'(status);
      if (pending_steps.size() == 0) begin
        $display("%0t unexpected beat: actual %p", $time, got);
        mismatch_count++;
      end else begin
        want = pending_steps.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    result_t none, want;
    none = '0;
    width_reg = 32; height_reg = 32;
    kept_x = 0; kept_y = 0;
    foreach (cell_score[i]) cell_score[i] = 0;
    idle_cycles(12);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 4);
    fill_grid(FILL_ZERO);
    want = '{next_x: 5'd3, next_y: 5'd2, step_direction: DIR_UP, target_x: 5'd0,
             target_y: 5'd0, path_length: 11'd0, status: ST_NO_TARGET};
    add_row(ACT_QUERY, 5'd3, 5'd2, 16'sd0, 1'b1, want);
    add_row(ACT_LOAD, 5'd3, 5'd3, 16'sd32767, 1'b0, none);
    want = '{next_x: 5'd3, next_y: 5'd3, step_direction: DIR_UP, target_x: 5'd3,
             target_y: 5'd3, path_length: 11'd0, status: ST_AT_TARGET};
    add_row(ACT_QUERY, 5'd3, 5'd3, -16'sd32768, 1'b1, want);
    add_row(ACT_QUERY, 5'd0, 5'd0, 16'sd0, 1'b0, none);
    add_row(ACT_QUERY, 5'd3, 5'd0, 16'sd0, 1'b0, none);
    add_row(ACT_LOAD, 5'd1, 5'd1, -16'sd32768, 1'b0, none);
    add_row(ACT_LOAD, 5'd2, 5'd1, 16'sd7, 1'b0, none);
    add_row(ACT_LOAD, 5'd2, 5'd2, 16'sd32767, 1'b0, none);
    add_row(ACT_QUERY, 5'd0, 5'd1, 16'sd0, 1'b0, none);
    add_row(ACT_QUERY, 5'd0, 5'd3, 16'sd0, 1'b0, none);
    add_row(ACT_LOAD, 5'd3, 5'd3, -16'sd1, 1'b0, none);
    add_row(ACT_QUERY, 5'd1, 5'd2, 16'sd0, 1'b0, none);
    add_row(ACT_LOAD, 5'd20, 5'd20, 16'sd32767, 1'b0, none);
    add_row(ACT_QUERY, 5'd0, 5'd0, 16'sd0, 1'b0, none);
    add_row(ACT_QUERY, 5'd9, 5'd9, 16'sd0, 1'b0, none);
    add_row(ACT_LOAD, 5'd1, 5'd0, -16'sd5, 1'b0, none);
    add_row(ACT_LOAD, 5'd0, 5'd1, -16'sd5, 1'b0, none);
    add_row(ACT_QUERY, 5'd0, 5'd0, 16'sd0, 1'b0, none);
    foreach (directed[i])
      send_beat(directed[i].act, directed[i].x, directed[i].y, directed[i].s,
                directed[i].fixed, directed[i].want, 1'b1);
    in_valid <= 1'b0;
    drain_results();

    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 1);
    for (int i = 0; i < 4; i++)
      send_beat(ACT_QUERY, 5'($urandom_range(0, 2)), 5'($urandom_range(0, 2)),
                16'($urandom), 1'b0, none, 1'b1);
    in_valid <= 1'b0;
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      write_reg(REG_WIDTH, $urandom_range(2, 4));
      write_reg(REG_HEIGHT, $urandom_range(2, 4));
      fill_grid(phase == 2 ? FILL_ANY : FILL_SMALL);
      if (phase == 1) hold_req = 1'b1;
      if (phase == 2) quiet_out = 1'b1;
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 2) == 0)
          send_beat(ACT_LOAD, 5'($urandom_range(0, 5)), 5'($urandom_range(0, 5)),
                    16'($urandom), 1'b0, none, phase != 2);
        else
          send_beat(ACT_QUERY, 5'($urandom_range(0, 5)), 5'($urandom_range(0, 5)),
                    16'($urandom), 1'b0, none, phase != 2);
      end
      in_valid <= 1'b0;
      drain_results();
    end

    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
